// File: sv/crsg_pkg.sv
// Shared types, constants and a helper function of the Catmull-Rom strip generator.
// No dependencies; the other files of the block, but for crsg_if, refer to it by scoped names.
package crsg_pkg;

   localparam int MAX_SEG_POINTS = 32;
   localparam int COORD_BITS = 16;
   localparam int SAT_BITS = (COORD_BITS > 16) ? 16 : COORD_BITS;
   localparam int SatHiInt = (1 << (SAT_BITS - 1)) - 1;
   localparam logic signed [23:0] SAT_HI = 24'(SatHiInt);
   localparam logic signed [23:0] SAT_LO = 24'(-SatHiInt - 1);

   localparam int ADDR_BITS = 5;
   localparam logic [2:0] REG_PPS        = 3'd0;
   localparam logic [2:0] REG_TOTAL      = 3'd1;
   localparam logic [2:0] REG_TSTEP      = 3'd2;
   localparam logic [2:0] REG_LAST_TSTEP = 3'd3;
   localparam logic [2:0] REG_HALF_WIDTH = 3'd4;
   localparam logic [2:0] REG_FALLOFF    = 3'd5;

   localparam logic [15:0] NORM_ONE = 16'd16384;
   localparam logic [21:0] T_ONE    = 22'd65536;

   typedef struct packed {
      logic [5:0]  points_per_segment;
      logic [11:0] total_points;
      logic [15:0] t_step;
      logic [15:0] last_t_step;
      logic [15:0] half_width;
      logic [15:0] width_falloff;
   } cfg_type;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
   } point_type;

   typedef struct packed {
      point_type [3:0] win;
      logic [5:0]      count;
      logic [15:0]     step;
      logic            fin;
      logic            run;
      logic            first;
   } cmd_type;

   typedef struct packed {
      logic signed [15:0] point_x;
      logic signed [15:0] point_y;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] left_x;
      logic signed [15:0] left_y;
      logic signed [15:0] right_x;
      logic signed [15:0] right_y;
      logic               run_last;
      logic               spline_end;
   } rsp_type;

   function automatic logic signed [15:0] sat_coord(input logic signed [23:0] v);
      logic signed [15:0] r;
      if (v > SAT_HI) begin
         r = 16'(SAT_HI);
      end else if (v < SAT_LO) begin
         r = 16'(SAT_LO);
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

// File: sv/crsg_if.sv
// Handshake channel interfaces of the strip generator: control points in, strip points out.
// Depends on nothing.
interface crsg_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] ctrl_x;
   logic signed [15:0] ctrl_y;
   logic               first;
   modport source(output valid, ctrl_x, ctrl_y, first, input ready);
   modport sink(input valid, ctrl_x, ctrl_y, first, output ready);
endinterface

interface crsg_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] point_x;
   logic signed [15:0] point_y;
   logic signed [15:0] normal_x;
   logic signed [15:0] normal_y;
   logic signed [15:0] left_x;
   logic signed [15:0] left_y;
   logic signed [15:0] right_x;
   logic signed [15:0] right_y;
   logic               run_last;
   logic               spline_end;
   modport source(output valid, point_x, point_y, normal_x, normal_y, left_x, left_y,
                  right_x, right_y, run_last, spline_end, input ready);
   modport sink(input valid, point_x, point_y, normal_x, normal_y, left_x, left_y,
                right_x, right_y, run_last, spline_end, output ready);
endinterface

// File: sv/catmull_rom_strip_generator_core.sv
// Top level of the Catmull-Rom strip generator: register file, front end, queue, point engine.
// Depends on crsg_pkg, crsg_if, crsg_front, crsg_cmdq and crsg_back.
//
//   channel   dir  handshake              carries
//   req_chan  in   valid/ready            ctrl_x, ctrl_y, first
//   rsp_chan  out  valid/ready            point, normal, left/right edge, run_last, spline_end
//   csr       in   psel/penable/pready    six registers at byte address 4*index
//
// A control point is taken whenever the two-entry queue has room.
// Each interpolated point passes through the engine: two axes of Horner steps on
// the one shared multiplier, a 25-step square root and two 16-step dividers for the normal.
// Synchronous reset clears all control state and loads the register defaults.
// A stalled result holds the engine; the front end keeps taking points until the queue fills.
module catmull_rom_strip_generator_core (
   input  logic                           clock,
   input  logic                           reset,
   crsg_req_if.sink                       req_chan,
   crsg_rsp_if.source                     rsp_chan,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [crsg_pkg::ADDR_BITS-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);

   crsg_pkg::cfg_type cfg_ff, cfg_in;
   crsg_pkg::cmd_type front_cmd, queue_cmd;
   logic front_valid, front_ready, queue_valid, queue_ready;
   logic [2:0] reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         case (reg_idx)
            crsg_pkg::REG_PPS:        cfg_in.points_per_segment = pwdata[5:0];
            crsg_pkg::REG_TOTAL:      cfg_in.total_points = pwdata[11:0];
            crsg_pkg::REG_TSTEP:      cfg_in.t_step = pwdata[15:0];
            crsg_pkg::REG_LAST_TSTEP: cfg_in.last_t_step = pwdata[15:0];
            crsg_pkg::REG_HALF_WIDTH: cfg_in.half_width = pwdata[15:0];
            crsg_pkg::REG_FALLOFF:    cfg_in.width_falloff = pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         crsg_pkg::REG_PPS:        prdata = 32'(cfg_ff.points_per_segment);
         crsg_pkg::REG_TOTAL:      prdata = 32'(cfg_ff.total_points);
         crsg_pkg::REG_TSTEP:      prdata = 32'(cfg_ff.t_step);
         crsg_pkg::REG_LAST_TSTEP: prdata = 32'(cfg_ff.last_t_step);
         crsg_pkg::REG_HALF_WIDTH: prdata = 32'(cfg_ff.half_width);
         crsg_pkg::REG_FALLOFF:    prdata = 32'(cfg_ff.width_falloff);
         default:                  prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.points_per_segment <= 6'd16;
         cfg_ff.total_points <= 12'd200;
         cfg_ff.t_step <= 16'd4096;
         cfg_ff.last_t_step <= 16'd4096;
         cfg_ff.half_width <= 16'd7936;
         cfg_ff.width_falloff <= 16'd40;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   crsg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_chan  (req_chan),
      .cmd_valid (front_valid),
      .cmd_ready (front_ready),
      .cmd       (front_cmd)
   );

   crsg_cmdq u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_cmd    (front_cmd),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_cmd   (queue_cmd)
   );

   crsg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (queue_valid),
      .cmd_ready (queue_ready),
      .cmd       (queue_cmd),
      .rsp_chan  (rsp_chan)
   );

endmodule

// File: sv/crsg_front.sv
// Front end: accepts control points, slides the window, splits the point budget into segments.
// Depends on crsg_pkg and crsg_req_if.
module crsg_front (
   input  logic                 clock,
   input  logic                 reset,
   input  crsg_pkg::cfg_type    cfg,
   crsg_req_if.sink             req_chan,
   output logic                 cmd_valid,
   input  logic                 cmd_ready,
   output crsg_pkg::cmd_type    cmd
);

   crsg_pkg::point_type [3:0] win_ff, win_in;
   logic [2:0]  fill_ff, fill_in;
   logic [11:0] left_ff, left_in;

   logic accept;

   assign req_chan.ready = cmd_ready;
   assign cmd_valid      = req_chan.valid;
   assign accept         = req_chan.valid & cmd_ready;

   always_comb begin
      crsg_pkg::point_type [3:0] base_win;
      logic [2:0]  base_fill;
      logic [11:0] base_left;
      logic [5:0]  pps;
      base_win  = req_chan.first ? '0 : win_ff;
      base_fill = req_chan.first ? 3'd0 : fill_ff;
      base_left = req_chan.first ? cfg.total_points : left_ff;
      pps = cfg.points_per_segment;
      if (pps == 6'd0) begin
         pps = 6'd1;
      end else if (pps > 6'(crsg_pkg::MAX_SEG_POINTS)) begin
         pps = 6'(crsg_pkg::MAX_SEG_POINTS);
      end
      win_in[0]   = base_win[1];
      win_in[1]   = base_win[2];
      win_in[2]   = base_win[3];
      win_in[3].x = req_chan.ctrl_x;
      win_in[3].y = req_chan.ctrl_y;
      fill_in = (base_fill < 3'd4) ? base_fill + 3'd1 : base_fill;
      left_in = base_left;
      cmd.win   = win_in;
      cmd.first = req_chan.first;
      cmd.run   = (fill_in == 3'd4) && (base_left != 12'd0);
      cmd.fin   = 1'b0;
      cmd.count = pps;
      cmd.step  = cfg.t_step;
      if (cmd.run) begin
         if (12'({pps, 1'b0}) > base_left) begin
            cmd.fin   = 1'b1;
            cmd.count = base_left[5:0];
            cmd.step  = cfg.last_t_step;
            left_in   = 12'd0;
         end else begin
            left_in = base_left - 12'(pps);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff  <= '0;
         fill_ff <= 3'd0;
         left_ff <= 12'd0;
      end else if (accept) begin
         win_ff  <= win_in;
         fill_ff <= fill_in;
         left_ff <= left_in;
      end
   end

endmodule

// File: sv/crsg_cmdq.sv
// Two-entry command queue between the front end and the point engine.
// Depends on crsg_pkg.
module crsg_cmdq (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  crsg_pkg::cmd_type in_cmd,
   output logic              out_valid,
   input  logic              out_ready,
   output crsg_pkg::cmd_type out_cmd
);

   crsg_pkg::cmd_type entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_cmd   = entry_ff[rd_ptr_ff];
   assign push      = in_valid & in_ready;
   assign pop       = out_valid & out_ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_in;
      end
   end

endmodule

// File: sv/crsg_back.sv
// Point engine: evaluates segment points on a shared multiplier, bit-serial square root and
// dividers for the normal, strip edges and the registered result. Depends on crsg_pkg, crsg_rsp_if.
module crsg_back (
   input  logic              clock,
   input  logic              reset,
   input  crsg_pkg::cfg_type cfg,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  crsg_pkg::cmd_type cmd,
   crsg_rsp_if.source        rsp_chan
);

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_M0   = 5'd1;
   localparam logic [4:0] S_M1   = 5'd2;
   localparam logic [4:0] S_M2   = 5'd3;
   localparam logic [4:0] S_M3   = 5'd4;
   localparam logic [4:0] S_M4   = 5'd5;
   localparam logic [4:0] S_M5   = 5'd6;
   localparam logic [4:0] S_M6   = 5'd7;
   localparam logic [4:0] S_M7   = 5'd8;
   localparam logic [4:0] S_PT   = 5'd9;
   localparam logic [4:0] S_N0   = 5'd10;
   localparam logic [4:0] S_N1   = 5'd11;
   localparam logic [4:0] S_N2   = 5'd12;
   localparam logic [4:0] S_SQ   = 5'd13;
   localparam logic [4:0] S_DS   = 5'd14;
   localparam logic [4:0] S_DV   = 5'd15;
   localparam logic [4:0] S_DF   = 5'd16;
   localparam logic [4:0] S_E0   = 5'd17;
   localparam logic [4:0] S_E1   = 5'd18;
   localparam logic [4:0] S_E2   = 5'd19;
   localparam logic [4:0] S_EW   = 5'd20;
   localparam logic [4:0] S_NEXT = 5'd21;

   logic [4:0] state_ff, state_in;
   logic       ax_ff, ax_in;

   logic signed [16:0] a_ff  [2];
   logic signed [16:0] a_in  [2];
   logic signed [19:0] b_ff  [2];
   logic signed [19:0] b_in  [2];
   logic signed [18:0] c_ff  [2];
   logic signed [18:0] c_in  [2];
   logic signed [15:0] p1_ff [2];
   logic signed [15:0] p1_in [2];

   logic [5:0]  idx_ff, idx_in, count_ff, count_in;
   logic [15:0] step_ff, step_in;
   logic        fin_ff, fin_in;
   logic [21:0] raw_ff, raw_in;

   logic signed [37:0] prod_ff, prod_in, part_ff, part_in, v_ff, v_in;
   logic signed [19:0] mul_a;
   logic signed [17:0] mul_b;

   crsg_pkg::point_type pt_ff, pt_in, held_ff, held_in, norm_ff, norm_in;
   logic        held_valid_ff, held_valid_in;
   logic [15:0] chw_ff, chw_in;
   logic        final_ff, final_in;

   logic signed [16:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [34:0] sq_ff, sq_in;
   logic [49:0] rad_ff, rad_in;
   logic [26:0] rem_ff, rem_in;
   logic [24:0] root_ff, root_in;
   logic [4:0]  iter_ff, iter_in;
   logic [24:0] rx_ff, rx_in, ry_ff, ry_in;
   logic [15:0] qx_ff, qx_in, qy_ff, qy_in;
   logic        negx_ff, negx_in, negy_ff, negy_in;
   logic signed [16:0] ox_ff, ox_in, oy_ff, oy_in;

   crsg_pkg::rsp_type out_ff, out_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [16:0] t17;
   logic signed [17:0] t18;

   function automatic logic signed [19:0] comp(input crsg_pkg::point_type p, input logic ax);
      return ax ? 20'(p.y) : 20'(p.x);
   endfunction

   assign t17 = (raw_ff > crsg_pkg::T_ONE) ? 17'h10000 : raw_ff[16:0];
   assign t18 = {1'b0, t17};
   assign prod_in = mul_a * mul_b;
   assign cmd_ready = (state_ff == S_IDLE);

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.point_x    = out_ff.point_x;
   assign rsp_chan.point_y    = out_ff.point_y;
   assign rsp_chan.normal_x   = out_ff.normal_x;
   assign rsp_chan.normal_y   = out_ff.normal_y;
   assign rsp_chan.left_x     = out_ff.left_x;
   assign rsp_chan.left_y     = out_ff.left_y;
   assign rsp_chan.right_x    = out_ff.right_x;
   assign rsp_chan.right_y    = out_ff.right_y;
   assign rsp_chan.run_last   = out_ff.run_last;
   assign rsp_chan.spline_end = out_ff.spline_end;

   always_comb begin
      logic signed [19:0] p0, p1, p2, p3;
      logic signed [55:0] s1;
      logic signed [57:0] s2;
      logic [34:0] sum;
      logic [28:0] rem_t, trial;
      logic [15:0] magx, magy;
      logic [38:0] dendx, dendy;
      logic [25:0] rtx, rty;
      logic        gex, gey;
      logic [15:0] qcx, qcy;
      state_in = state_ff;
      ax_in = ax_ff;
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      p1_in = p1_ff;
      idx_in = idx_ff;
      count_in = count_ff;
      step_in = step_ff;
      fin_in = fin_ff;
      raw_in = raw_ff;
      part_in = part_ff;
      v_in = v_ff;
      mul_a = '0;
      mul_b = '0;
      pt_in = pt_ff;
      held_in = held_ff;
      norm_in = norm_ff;
      held_valid_in = held_valid_ff;
      chw_in = chw_ff;
      final_in = final_ff;
      dx_in = dx_ff;
      dy_in = dy_ff;
      sq_in = sq_ff;
      rad_in = rad_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      iter_in = iter_ff;
      rx_in = rx_ff;
      ry_in = ry_ff;
      qx_in = qx_ff;
      qy_in = qy_ff;
      negx_in = negx_ff;
      negy_in = negy_ff;
      ox_in = ox_ff;
      oy_in = oy_ff;
      out_in = out_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;
      s1 = '0;
      s2 = '0;
      sum = sq_ff + prod_ff[34:0];
      rem_t = {rem_ff, rad_ff[49:48]};
      trial = {2'b00, root_ff, 2'b01};
      magx = dx_ff[16] ? 16'(-dx_ff) : dx_ff[15:0];
      magy = dy_ff[16] ? 16'(-dy_ff) : dy_ff[15:0];
      dendx = {1'b0, magy, 22'd0} + 39'(root_ff >> 1);
      dendy = {1'b0, magx, 22'd0} + 39'(root_ff >> 1);
      rtx = {rx_ff, qx_ff[15]};
      rty = {ry_ff, qy_ff[15]};
      gex = (rtx >= {1'b0, root_ff});
      gey = (rty >= {1'b0, root_ff});
      qcx = (qx_ff > crsg_pkg::NORM_ONE) ? crsg_pkg::NORM_ONE : qx_ff;
      qcy = (qy_ff > crsg_pkg::NORM_ONE) ? crsg_pkg::NORM_ONE : qy_ff;
      p0 = '0;
      p1 = '0;
      p2 = '0;
      p3 = '0;
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               if (cmd.first) begin
                  held_valid_in = 1'b0;
                  norm_in = '0;
                  chw_in = cfg.half_width;
               end
               if (cmd.run) begin
                  for (int k = 0; k < 2; k++) begin
                     p0 = comp(cmd.win[0], 1'(k));
                     p1 = comp(cmd.win[1], 1'(k));
                     p2 = comp(cmd.win[2], 1'(k));
                     p3 = comp(cmd.win[3], 1'(k));
                     a_in[k]  = 17'(p2 - p0);
                     b_in[k]  = (p0 <<< 1) - (p1 <<< 2) - p1 + (p2 <<< 2) - p3;
                     c_in[k]  = 19'(p3 - p0 + (p1 <<< 1) + p1 - (p2 <<< 1) - p2);
                     p1_in[k] = p1[15:0];
                  end
                  count_in = cmd.count;
                  step_in = cmd.step;
                  fin_in = cmd.fin;
                  idx_in = 6'd0;
                  raw_in = 22'd0;
                  ax_in = 1'b0;
                  state_in = S_M0;
               end
            end
         end
         S_M0: begin
            mul_a = 20'(c_ff[ax_ff]);
            mul_b = t18;
            state_in = S_M1;
         end
         S_M1: begin
            v_in = prod_ff + (38'(b_ff[ax_ff]) <<< 16);
            state_in = S_M2;
         end
         S_M2: begin
            mul_a = {2'b00, v_ff[17:0]};
            mul_b = t18;
            state_in = S_M3;
         end
         S_M3: begin
            part_in = prod_ff;
            mul_a = {v_ff[36], v_ff[36:18]};
            mul_b = t18;
            state_in = S_M4;
         end
         S_M4: begin
            s1 = (56'(prod_ff) <<< 18) + 56'(part_ff) + (56'sd1 <<< 15);
            v_in = 38'(s1 >>> 16) + (38'(a_ff[ax_ff]) <<< 16);
            state_in = S_M5;
         end
         S_M5: begin
            mul_a = {1'b0, v_ff[18:0]};
            mul_b = t18;
            state_in = S_M6;
         end
         S_M6: begin
            part_in = prod_ff;
            mul_a = {v_ff[37], v_ff[37:19]};
            mul_b = t18;
            state_in = S_M7;
         end
         S_M7: begin
            s2 = (58'(prod_ff) <<< 19) + 58'(part_ff) + (58'(p1_ff[ax_ff]) <<< 33)
                 + (58'sd1 <<< 32);
            if (ax_ff) begin
               pt_in.y = crsg_pkg::sat_coord(24'(s2 >>> 33));
               ax_in = 1'b0;
               state_in = S_PT;
            end else begin
               pt_in.x = crsg_pkg::sat_coord(24'(s2 >>> 33));
               ax_in = 1'b1;
               state_in = S_M0;
            end
         end
         S_PT: begin
            if (held_valid_ff) begin
               dx_in = 17'(pt_ff.x) - 17'(held_ff.x);
               dy_in = 17'(pt_ff.y) - 17'(held_ff.y);
               state_in = S_N0;
            end else begin
               held_in = pt_ff;
               held_valid_in = 1'b1;
               state_in = S_NEXT;
            end
         end
         S_N0: begin
            mul_a = 20'(dx_ff);
            mul_b = 18'(dx_ff);
            state_in = S_N1;
         end
         S_N1: begin
            sq_in = prod_ff[34:0];
            mul_a = 20'(dy_ff);
            mul_b = 18'(dy_ff);
            state_in = S_N2;
         end
         S_N2: begin
            if (sum == 35'd0) begin
               norm_in = '0;
               state_in = S_E0;
            end else begin
               rad_in = {sum[33:0], 16'd0};
               rem_in = '0;
               root_in = '0;
               iter_in = 5'd0;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            if (rem_t >= trial) begin
               rem_in = 27'(rem_t - trial);
               root_in = {root_ff[23:0], 1'b1};
            end else begin
               rem_in = rem_t[26:0];
               root_in = {root_ff[23:0], 1'b0};
            end
            rad_in = {rad_ff[47:0], 2'b00};
            iter_in = iter_ff + 5'd1;
            if (iter_ff == 5'd24) begin
               state_in = S_DS;
            end
         end
         S_DS: begin
            rx_in = {2'b00, dendx[38:16]};
            qx_in = dendx[15:0];
            ry_in = {2'b00, dendy[38:16]};
            qy_in = dendy[15:0];
            negx_in = ~dy_ff[16];
            negy_in = dx_ff[16];
            iter_in = 5'd0;
            state_in = S_DV;
         end
         S_DV: begin
            rx_in = gex ? 25'(rtx - {1'b0, root_ff}) : rtx[24:0];
            ry_in = gey ? 25'(rty - {1'b0, root_ff}) : rty[24:0];
            qx_in = {qx_ff[14:0], gex};
            qy_in = {qy_ff[14:0], gey};
            iter_in = iter_ff + 5'd1;
            if (iter_ff == 5'd15) begin
               state_in = S_DF;
            end
         end
         S_DF: begin
            norm_in.x = negx_ff ? -qcx : qcx;
            norm_in.y = negy_ff ? -qcy : qcy;
            state_in = S_E0;
         end
         S_E0: begin
            mul_a = 20'(norm_ff.x);
            mul_b = {2'b00, chw_ff};
            state_in = S_E1;
         end
         S_E1: begin
            ox_in = 17'((prod_ff + (38'sd1 <<< 18)) >>> 19);
            mul_a = 20'(norm_ff.y);
            mul_b = {2'b00, chw_ff};
            state_in = S_E2;
         end
         S_E2: begin
            oy_in = 17'((prod_ff + (38'sd1 <<< 18)) >>> 19);
            state_in = S_EW;
         end
         S_EW: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               out_in.point_x = held_ff.x;
               out_in.point_y = held_ff.y;
               out_in.normal_x = norm_ff.x;
               out_in.normal_y = norm_ff.y;
               out_in.left_x = crsg_pkg::sat_coord(24'(held_ff.x) + 24'(ox_ff));
               out_in.left_y = crsg_pkg::sat_coord(24'(held_ff.y) + 24'(oy_ff));
               out_in.right_x = crsg_pkg::sat_coord(24'(held_ff.x) - 24'(ox_ff));
               out_in.right_y = crsg_pkg::sat_coord(24'(held_ff.y) - 24'(oy_ff));
               out_in.run_last = final_ff | (~fin_ff & (idx_ff == count_ff - 6'd1));
               out_in.spline_end = final_ff;
               chw_in = (chw_ff > cfg.width_falloff) ? chw_ff - cfg.width_falloff : 16'd0;
               if (final_ff) begin
                  held_valid_in = 1'b0;
                  final_in = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  held_in = pt_ff;
                  held_valid_in = 1'b1;
                  state_in = S_NEXT;
               end
            end
         end
         S_NEXT: begin
            if (idx_ff == count_ff - 6'd1) begin
               if (fin_ff) begin
                  final_in = 1'b1;
                  state_in = S_E0;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               idx_in = idx_ff + 6'd1;
               raw_in = raw_ff + 22'(step_ff);
               state_in = S_M0;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      part_ff <= part_in;
      v_ff <= v_in;
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      p1_ff <= p1_in;
      idx_ff <= idx_in;
      count_ff <= count_in;
      step_ff <= step_in;
      fin_ff <= fin_in;
      raw_ff <= raw_in;
      pt_ff <= pt_in;
      held_ff <= held_in;
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      sq_ff <= sq_in;
      rad_ff <= rad_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
      iter_ff <= iter_in;
      rx_ff <= rx_in;
      ry_ff <= ry_in;
      qx_ff <= qx_in;
      qy_ff <= qy_in;
      negx_ff <= negx_in;
      negy_ff <= negy_in;
      ox_ff <= ox_in;
      oy_ff <= oy_in;
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ax_ff <= 1'b0;
         held_valid_ff <= 1'b0;
         norm_ff <= '0;
         chw_ff <= 16'd0;
         final_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ax_ff <= ax_in;
         held_valid_ff <= held_valid_in;
         norm_ff <= norm_in;
         chw_ff <= chw_in;
         final_ff <= final_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: dv/crsg_strip_checker.sv
// Checker for the strip generator: watches the control point, strip point and register ports,
// predicts every strip point and compares. Depends on crsg_pkg and crsg_if.
`timescale 1ns / 1ps
module crsg_strip_checker (
   input  logic                           clock,
   input  logic                           reset,
   crsg_req_if                            req_chan,
   crsg_rsp_if                            rsp_chan,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic                           pready,
   input  logic [crsg_pkg::ADDR_BITS-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output int                             fail_count,
   output int                             pending
);

   crsg_pkg::cfg_type cfg;
   crsg_pkg::rsp_type strip_q[$];
   longint  win_x[4], win_y[4];
   int      fill;
   int      budget;
   longint  held_x, held_y, norm_x, norm_y;
   bit      held_ok;
   longint  cur_hw;

   function automatic longint round_shift(input longint x, input int k);
      return (x + (64'sd1 <<< (k - 1))) >>> k;
   endfunction

   function automatic longint clamp_coord(input longint v);
      if (v > longint'(crsg_pkg::SAT_HI)) return longint'(crsg_pkg::SAT_HI);
      if (v < longint'(crsg_pkg::SAT_LO)) return longint'(crsg_pkg::SAT_LO);
      return v;
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint unit_div(input longint num, input longint unsigned den);
      longint unsigned m, q;
      m = (num < 0) ? longint'(-num) : num;
      q = (m + den / 2) / den;
      if (q > 16384) q = 16384;
      return (num < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint spline_at(input longint p0, p1, p2, p3, input longint t);
      longint a, b, c, v;
      a = p2 - p0;
      b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
      c = -p0 + 3 * p1 - 3 * p2 + p3;
      v = c * t + b * 65536;
      v = round_shift(v * t, 16) + a * 65536;
      v = v * t + p1 * 2 * 64'sd4294967296;
      return clamp_coord(round_shift(v, 33));
   endfunction

   task automatic emit_strip_point(input bit spline_done);
      crsg_pkg::rsp_type r;
      longint  ox, oy;
      ox = round_shift(norm_x * cur_hw, 19);
      oy = round_shift(norm_y * cur_hw, 19);
      r.point_x    = 16'(held_x);
      r.point_y    = 16'(held_y);
      r.normal_x   = 16'(norm_x);
      r.normal_y   = 16'(norm_y);
      r.left_x     = 16'(clamp_coord(held_x + ox));
      r.left_y     = 16'(clamp_coord(held_y + oy));
      r.right_x    = 16'(clamp_coord(held_x - ox));
      r.right_y    = 16'(clamp_coord(held_y - oy));
      r.run_last   = 1'b0;
      r.spline_end = spline_done;
      strip_q.insert(strip_q.size(), r);
      cur_hw = (cur_hw > longint'(cfg.width_falloff)) ? cur_hw - cfg.width_falloff : 0;
   endtask

   task automatic take_ctrl_point(input logic signed [15:0] cx, cy, input logic first);
      int      pps, n, start_cnt;
      longint  stp, t, px, py, dx, dy;
      bit      fin;
      longint unsigned len;
      start_cnt = strip_q.size();
      if (first) begin
         foreach (win_x[k]) begin
            win_x[k] = 0;
            win_y[k] = 0;
         end
         fill = 0;
         budget = cfg.total_points;
         held_ok = 0;
         norm_x = 0;
         norm_y = 0;
         cur_hw = cfg.half_width;
      end
      for (int k = 0; k < 3; k++) begin
         win_x[k] = win_x[k + 1];
         win_y[k] = win_y[k + 1];
      end
      win_x[3] = cx;
      win_y[3] = cy;
      if (fill < 4) fill++;
      if (fill == 4 && budget > 0) begin
         pps = cfg.points_per_segment;
         if (pps < 1) pps = 1;
         if (pps > crsg_pkg::MAX_SEG_POINTS) pps = crsg_pkg::MAX_SEG_POINTS;
         if (2 * pps > budget) begin
            n = budget;
            fin = 1;
            stp = cfg.last_t_step;
            budget = 0;
         end else begin
            n = pps;
            fin = 0;
            stp = cfg.t_step;
            budget -= pps;
         end
         for (int i = 0; i < n; i++) begin
            t = i * stp;
            if (t > 65536) t = 65536;
            px = spline_at(win_x[0], win_x[1], win_x[2], win_x[3], t);
            py = spline_at(win_y[0], win_y[1], win_y[2], win_y[3], t);
            if (held_ok) begin
               dx = px - held_x;
               dy = py - held_y;
               if (dx == 0 && dy == 0) begin
                  norm_x = 0;
                  norm_y = 0;
               end else begin
                  len = int_sqrt((dx * dx + dy * dy) * 65536);
                  norm_x = unit_div(-dy * 4194304, len);
                  norm_y = unit_div(dx * 4194304, len);
               end
               emit_strip_point(1'b0);
            end
            held_x = px;
            held_y = py;
            held_ok = 1;
         end
         if (fin && held_ok) begin
            emit_strip_point(1'b1);
            held_ok = 0;
         end
      end
      if (strip_q.size() > start_cnt) strip_q[strip_q.size() - 1].run_last = 1'b1;
   endtask

   task automatic check_field(input string name, input logic [15:0] exp_v, act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      crsg_pkg::rsp_type e;
      if (reset) begin
         cfg.points_per_segment = 16;
         cfg.total_points = 200;
         cfg.t_step = 4096;
         cfg.last_t_step = 4096;
         cfg.half_width = 7936;
         cfg.width_falloff = 40;
         foreach (win_x[k]) begin
            win_x[k] = 0;
            win_y[k] = 0;
         end
         fill = 0;
         budget = 0;
         held_ok = 0;
         held_x = 0;
         held_y = 0;
         norm_x = 0;
         norm_y = 0;
         cur_hw = 0;
         fail_count = 0;
         strip_q.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
               crsg_pkg::REG_PPS:        cfg.points_per_segment = pwdata[5:0];
               crsg_pkg::REG_TOTAL:      cfg.total_points = pwdata[11:0];
               crsg_pkg::REG_TSTEP:      cfg.t_step = pwdata[15:0];
               crsg_pkg::REG_LAST_TSTEP: cfg.last_t_step = pwdata[15:0];
               crsg_pkg::REG_HALF_WIDTH: cfg.half_width = pwdata[15:0];
               crsg_pkg::REG_FALLOFF:    cfg.width_falloff = pwdata[15:0];
               default: ;
            endcase
         end
         if (req_chan.valid && req_chan.ready)
            take_ctrl_point(req_chan.ctrl_x, req_chan.ctrl_y, req_chan.first);
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (strip_q.size() == 0) begin
               $error("strip point with no transaction expected");
               fail_count++;
            end else begin
               e = strip_q.pop_front();
               check_field("point_x", e.point_x, rsp_chan.point_x);
               check_field("point_y", e.point_y, rsp_chan.point_y);
               check_field("normal_x", e.normal_x, rsp_chan.normal_x);
               check_field("normal_y", e.normal_y, rsp_chan.normal_y);
               check_field("left_x", e.left_x, rsp_chan.left_x);
               check_field("left_y", e.left_y, rsp_chan.left_y);
               check_field("right_x", e.right_x, rsp_chan.right_x);
               check_field("right_y", e.right_y, rsp_chan.right_y);
               check_field("run_last", 16'(e.run_last), 16'(rsp_chan.run_last));
               check_field("spline_end", 16'(e.spline_end), 16'(rsp_chan.spline_end));
            end
         end
      end
      pending = strip_q.size();
   end

endmodule

// File: dv/tb_catmull_rom_strip_generator_core.sv
// Top of the strip generator testbench: clock, reset, control point and register stimulus.
// Depends on crsg_pkg, crsg_if, crsg_strip_checker and catmull_rom_strip_generator_core.
`timescale 1ns / 1ps
module tb_catmull_rom_strip_generator_core;

   localparam logic [2:0] REG_UNMAPPED = 3'd6;

   logic                           clock;
   logic                           reset;
   logic                           psel, penable, pwrite, pready;
   logic [crsg_pkg::ADDR_BITS-1:0] paddr;
   logic [31:0]                    pwdata, prdata;
   logic                           calm, hold_start;
   int                             hold_cnt, fail_count, pending, sent;

   crsg_req_if req_if();
   crsg_rsp_if rsp_if();

   catmull_rom_strip_generator_core DUT (
      .clock(clock), .reset(reset), .req_chan(req_if.sink), .rsp_chan(rsp_if.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
      .prdata(prdata), .pready(pready)
   );

   crsg_strip_checker checker_i (
      .clock(clock), .reset(reset), .req_chan(req_if), .rsp_chan(rsp_if), .psel(psel),
      .penable(penable), .pwrite(pwrite), .pready(pready), .paddr(paddr), .pwdata(pwdata),
      .fail_count(fail_count), .pending(pending)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         hold_cnt <= 0;
      end else if (hold_start) begin
         rsp_if.ready <= 1'b0;
         hold_cnt <= 800;
      end else if (hold_cnt != 0) begin
         rsp_if.ready <= 1'b0;
         hold_cnt <= hold_cnt - 1;
      end else begin
         rsp_if.ready <= calm || ($urandom_range(99) >= 34);
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] v);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic load_config(input int pps, total, ts, lts, hw, fo);
      csr_write(crsg_pkg::REG_PPS, pps);
      csr_write(crsg_pkg::REG_TOTAL, total);
      csr_write(crsg_pkg::REG_TSTEP, ts);
      csr_write(crsg_pkg::REG_LAST_TSTEP, lts);
      csr_write(crsg_pkg::REG_HALF_WIDTH, hw);
      csr_write(crsg_pkg::REG_FALLOFF, fo);
   endtask

   task automatic send_cp(input logic signed [15:0] x, y, input logic first);
      while (!calm && $urandom_range(99) < 34) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.ctrl_x <= x;
      req_if.ctrl_y <= y;
      req_if.first <= first;
      @(negedge clock);
      while (!req_if.ready) @(negedge clock);
      @(posedge clock);
      sent++;
   endtask

   // hold off new control points until every strip point is back, then let the engine settle
   task automatic drain;
      req_if.valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (600) @(posedge clock);
   endtask

   task automatic random_spline(input int n);
      logic signed [15:0] x, y;
      bit                 wide;
      wide = ($urandom_range(3) == 0);
      x = 16'($urandom);
      y = 16'($urandom);
      for (int i = 0; i < n; i++) begin
         send_cp(x, y, i == 0);
         if (wide) begin
            x = 16'($urandom);
            y = 16'($urandom);
         end else begin
            x = x + 16'($urandom_range(800) - 400);
            y = y + 16'($urandom_range(800) - 400);
         end
      end
   endtask

   initial begin
      #20ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      req_if.valid <= 1'b0;
      req_if.ctrl_x <= '0;
      req_if.ctrl_y <= '0;
      req_if.first <= 1'b0;
      calm <= 1'b0;
      hold_start <= 1'b0;
      sent = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // no spline started yet: window slides, nothing comes out
      send_cp(16'sd100, -16'sd100, 1'b0);
      send_cp(16'sh8000, 16'sd32767, 1'b0);
      drain();

      // one-point spline, then spent budget; also hit the unmapped register
      load_config(1, 1, 4096, 4096, 7936, 40);
      csr_write(REG_UNMAPPED, 32'hFFFF_FFFF);
      send_cp(16'sd10, 16'sd20, 1'b1);
      send_cp(16'sd30, 16'sd40, 1'b0);
      send_cp(16'sd50, -16'sd60, 1'b0);
      send_cp(16'sd70, 16'sd80, 1'b0);
      send_cp(16'sd90, 16'sd99, 1'b0);
      drain();

      // zero segment size, maximum t step, full scale coordinates, taper to zero
      load_config(0, 5, 65535, 65535, 65535, 65535);
      send_cp(16'sd32767, 16'sh8000, 1'b1);
      send_cp(16'sh8000, 16'sd32767, 1'b0);
      send_cp(16'sd32767, 16'sd32767, 1'b0);
      send_cp(16'sh8000, 16'sh8000, 1'b0);
      send_cp(16'sd0, 16'sd0, 1'b0);
      send_cp(16'sd0, 16'sd0, 1'b0);
      drain();

      // oversize segment count and repeated points: zero tangent
      load_config(63, 4095, 1, 1, 0, 0);
      for (int i = 0; i < 5; i++) send_cp(16'sd5, 16'sd5, i == 0);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         load_config(($urandom_range(7) == 0) ? 32 : $urandom_range(1, 6),
                     ($urandom_range(5) == 0) ? 4095 : $urandom_range(2, 60),
                     $urandom_range(1, 65535), $urandom_range(1, 65535),
                     $urandom_range(0, 65535),
                     ($urandom_range(3) == 0) ? $urandom_range(0, 65535)
                                              : $urandom_range(0, 2000));
         calm <= (ph == 2);
         if (ph == 1) begin
            hold_start <= 1'b1;
            @(posedge clock);
            hold_start <= 1'b0;
         end
         while (sent < 20 + 23 * (ph + 1)) begin
            if ($urandom_range(5) == 0)
               send_cp(16'($urandom), 16'($urandom), 1'b0);
            else
               random_spline($urandom_range(4, 10));
         end
         drain();
      end
      calm <= 1'b0;

      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
